>>> rtl/smcd_pkg.sv
// Package for the serial motor command driver: item types, status codes,
// character constants and the speed-to-drive function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smcd_pkg;

    localparam int CMD_MAX_LEN = 16;
    localparam int CNT_W       = $clog2(CMD_MAX_LEN + 1);

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_M1   = 8'h31;
    localparam logic [7:0] CHAR_M2   = 8'h32;
    localparam logic [7:0] SPEED_MID = 8'd127;

    localparam logic [9:0] DUTY_MAX       = 10'h3FF;
    localparam logic [9:0] THRESHOLD_INIT = 10'd1023;

    localparam logic [2:0] ST_PENDING     = 3'd0;
    localparam logic [2:0] ST_ACCEPTED    = 3'd1;
    localparam logic [2:0] ST_TOO_LONG    = 3'd2;
    localparam logic [2:0] ST_BAD_LENGTH  = 3'd3;
    localparam logic [2:0] ST_BAD_MOTOR   = 3'd4;
    localparam logic [2:0] ST_OVERCURRENT = 3'd5;

    localparam logic ACT_BYTE   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] byte_value;
        logic [9:0] sample_value;
    } t_cmd_in;

    typedef struct packed {
        logic [2:0] status;
        logic [9:0] motor1_duty;
        logic       motor1_forward;
        logic [9:0] motor2_duty;
        logic       motor2_forward;
        logic       sample_channel;
    } t_cmd_out;

    typedef struct packed {
        logic [9:0] duty;
        logic       forward;
    } t_drive;

    function automatic t_drive speed_to_drive(input logic [7:0] speed);
        t_drive     d;
        logic [7:0] mag;
        if (speed >= SPEED_MID) begin
            d.forward = 1'b1;
            mag       = speed - SPEED_MID;
        end else begin
            d.forward = 1'b0;
            mag       = SPEED_MID - speed;
        end
        if (mag[7]) begin
            d.duty = DUTY_MAX;
        end else begin
            d.duty = {mag[6:0], 3'b000};
        end
        return d;
    endfunction

endpackage

`default_nettype wire

>>> rtl/smcd_engine.sv
// Command parser and motor state of the serial motor command driver.
// Holds the threshold and motor registers; depends on smcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smcd_engine (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire smcd_pkg::t_cmd_in i_item,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [9:0]        i_cfg_wr_data,
    output smcd_pkg::t_cmd_out     o_result
);

    logic [9:0]                 r_threshold;
    logic [smcd_pkg::CNT_W-1:0] r_byte_count;
    logic [7:0]                 r_first_byte;
    logic [7:0]                 r_second_byte;
    logic [9:0]                 r_m1_duty;
    logic                       r_m1_fwd;
    logic [9:0]                 r_m2_duty;
    logic                       r_m2_fwd;
    logic                       r_channel;

    logic [smcd_pkg::CNT_W-1:0] n_byte_count;
    logic [7:0]                 n_first_byte;
    logic [7:0]                 n_second_byte;
    logic [9:0]                 n_m1_duty;
    logic                       n_m1_fwd;
    logic [9:0]                 n_m2_duty;
    logic                       n_m2_fwd;
    logic                       n_channel;
    logic [2:0]                 status;
    logic [smcd_pkg::CNT_W-1:0] count_inc;
    smcd_pkg::t_drive           drive;

    assign drive     = smcd_pkg::speed_to_drive(r_second_byte);
    assign count_inc = r_byte_count + smcd_pkg::CNT_W'(1);

    always_comb begin
        n_byte_count  = r_byte_count;
        n_first_byte  = r_first_byte;
        n_second_byte = r_second_byte;
        n_m1_duty     = r_m1_duty;
        n_m1_fwd      = r_m1_fwd;
        n_m2_duty     = r_m2_duty;
        n_m2_fwd      = r_m2_fwd;
        n_channel     = r_channel;
        status        = smcd_pkg::ST_PENDING;
        if (i_item.action == smcd_pkg::ACT_BYTE) begin
            if (i_item.byte_value == smcd_pkg::CHAR_CR) begin
                priority if (r_byte_count != smcd_pkg::CNT_W'(2)) begin
                    status = smcd_pkg::ST_BAD_LENGTH;
                end else if (r_first_byte == smcd_pkg::CHAR_M1) begin
                    n_m1_duty = drive.duty;
                    n_m1_fwd  = drive.forward;
                    status    = smcd_pkg::ST_ACCEPTED;
                end else if (r_first_byte == smcd_pkg::CHAR_M2) begin
                    n_m2_duty = drive.duty;
                    n_m2_fwd  = drive.forward;
                    status    = smcd_pkg::ST_ACCEPTED;
                end else begin
                    status = smcd_pkg::ST_BAD_MOTOR;
                end
                n_byte_count = '0;
            end else begin
                if (r_byte_count == smcd_pkg::CNT_W'(0)) begin
                    n_first_byte = i_item.byte_value;
                end
                if (r_byte_count == smcd_pkg::CNT_W'(1)) begin
                    n_second_byte = i_item.byte_value;
                end
                if (count_inc >= smcd_pkg::CNT_W'(smcd_pkg::CMD_MAX_LEN)) begin
                    status       = smcd_pkg::ST_TOO_LONG;
                    n_byte_count = '0;
                end else begin
                    n_byte_count = count_inc;
                end
            end
        end else begin
            if (i_item.sample_value > r_threshold) begin
                n_m1_duty = '0;
                n_m1_fwd  = 1'b1;
                n_m2_duty = '0;
                n_m2_fwd  = 1'b1;
                status    = smcd_pkg::ST_OVERCURRENT;
            end
            n_channel = ~r_channel;
        end
    end

    always_comb begin
        o_result.status         = status;
        o_result.motor1_duty    = n_m1_duty;
        o_result.motor1_forward = n_m1_fwd;
        o_result.motor2_duty    = n_m2_duty;
        o_result.motor2_forward = n_m2_fwd;
        o_result.sample_channel = n_channel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= smcd_pkg::THRESHOLD_INIT;
            r_byte_count  <= '0;
            r_first_byte  <= '0;
            r_second_byte <= '0;
            r_m1_duty     <= '0;
            r_m1_fwd      <= 1'b1;
            r_m2_duty     <= '0;
            r_m2_fwd      <= 1'b1;
            r_channel     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_threshold <= i_cfg_wr_data;
            end
            if (i_fire) begin
                r_byte_count  <= n_byte_count;
                r_first_byte  <= n_first_byte;
                r_second_byte <= n_second_byte;
                r_m1_duty     <= n_m1_duty;
                r_m1_fwd      <= n_m1_fwd;
                r_m2_duty     <= n_m2_duty;
                r_m2_fwd      <= n_m2_fwd;
                r_channel     <= n_channel;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/serial_motor_command_driver_core.sv
// Top level of the serial motor command driver: input register, result
// register and handshakes around smcd_engine; depends on smcd_pkg.
//
// Channel   Direction  Handshake                  Payload
// in        to block   i_in_valid / o_in_stall    i_in_item  (t_cmd_in)
// out       from block o_out_valid / i_out_stall  o_out_item (t_cmd_out)
// cfg       to block   i_cfg_wr_en                i_cfg_wr_data (threshold)
//
// Each item passes through the input register and then the result register.
// One item is accepted every cycle while the input side is not stalled.
// Reset is synchronous and empties both registers and clears all command state.
// A stall on the output holds the result and then the input register;
// the input side stalls only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module serial_motor_command_driver_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire smcd_pkg::t_cmd_in  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output smcd_pkg::t_cmd_out      o_out_item,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [9:0]         i_cfg_wr_data
);

    logic               r_in_valid;
    smcd_pkg::t_cmd_in  r_in_item;
    logic               r_out_valid;
    smcd_pkg::t_cmd_out r_out_item;
    smcd_pkg::t_cmd_out result;
    logic               out_blocked;
    logic               fire;

    assign out_blocked = r_out_valid && i_out_stall;
    assign fire        = r_in_valid && !out_blocked;
    assign o_in_stall  = r_in_valid && out_blocked;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    smcd_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_item        (r_in_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (!out_blocked) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (fire) begin
            r_out_item <= result;
        end
    end

`ifndef SYNTHESIS
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("pipeline not empty after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk)
        o_in_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled while a register is free");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("processed item did not reach the result register");

    a_overcurrent_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == smcd_pkg::ST_OVERCURRENT |->
        o_out_item.motor1_duty == 10'd0 && o_out_item.motor2_duty == 10'd0 &&
        o_out_item.motor1_forward && o_out_item.motor2_forward)
        else $error("overcurrent result does not show both motors stopped");
`endif

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for serial_motor_command_driver_core: serial commands,
// current samples and threshold writes, checked against a drive-state tracker.
// Depends on smcd_pkg and the RTL of the core.
`timescale 1ns / 1ps

module tb_top;

    localparam int RESET_CYCLES = 2;
    localparam int RANDOM_ITEMS = 800;
    localparam int PHASES       = 6;
    localparam int TAIL_CYCLES  = 10;
    localparam int LIMIT_CYCLES = 200000;
    localparam int MAX_IDLE     = 7;

    class drive_tracker;
        localparam int          CMD_LEN      = 2;
        localparam logic [7:0]  MAG_SATURATE = 8'd128;
        localparam logic [9:0]  DUTY_STEP    = 10'd8;

        logic [9:0]         threshold;
        int                 byte_count;
        logic [7:0]         first_byte;
        logic [7:0]         second_byte;
        logic [9:0]         m1_duty;
        logic               m1_fwd;
        logic [9:0]         m2_duty;
        logic               m2_fwd;
        logic               channel;
        smcd_pkg::t_cmd_out drive_q[$];
        int                 errors;

        function new();
            threshold   = smcd_pkg::THRESHOLD_INIT;
            byte_count  = 0;
            first_byte  = '0;
            second_byte = '0;
            m1_duty     = '0;
            m1_fwd      = 1'b1;
            m2_duty     = '0;
            m2_fwd      = 1'b1;
            channel     = 1'b0;
            errors      = 0;
        endfunction

        function void speed_drive(input logic [7:0] speed, output logic [9:0] duty,
                                  output logic fwd);
            logic [7:0] mag;
            if (speed >= smcd_pkg::SPEED_MID) begin
                fwd = 1'b1;
                mag = speed - smcd_pkg::SPEED_MID;
            end else begin
                fwd = 1'b0;
                mag = smcd_pkg::SPEED_MID - speed;
            end
            if (mag >= MAG_SATURATE) begin
                duty = smcd_pkg::DUTY_MAX;
            end else begin
                duty = 10'(mag) * DUTY_STEP;
            end
        endfunction

        function void note_item(input smcd_pkg::t_cmd_in it);
            smcd_pkg::t_cmd_out next;
            logic [2:0]         status;
            status = smcd_pkg::ST_PENDING;
            if (it.action == smcd_pkg::ACT_BYTE) begin
                if (it.byte_value == smcd_pkg::CHAR_CR) begin
                    if (byte_count != CMD_LEN) begin
                        status = smcd_pkg::ST_BAD_LENGTH;
                    end else if (first_byte != smcd_pkg::CHAR_M1 &&
                                 first_byte != smcd_pkg::CHAR_M2) begin
                        status = smcd_pkg::ST_BAD_MOTOR;
                    end else begin
                        if (first_byte == smcd_pkg::CHAR_M1) begin
                            speed_drive(second_byte, m1_duty, m1_fwd);
                        end else begin
                            speed_drive(second_byte, m2_duty, m2_fwd);
                        end
                        status = smcd_pkg::ST_ACCEPTED;
                    end
                    byte_count = 0;
                end else begin
                    if (byte_count == 0) begin
                        first_byte = it.byte_value;
                    end else if (byte_count == 1) begin
                        second_byte = it.byte_value;
                    end
                    byte_count++;
                    if (byte_count >= smcd_pkg::CMD_MAX_LEN) begin
                        status     = smcd_pkg::ST_TOO_LONG;
                        byte_count = 0;
                    end
                end
            end else begin
                if (it.sample_value > threshold) begin
                    speed_drive(smcd_pkg::SPEED_MID, m2_duty, m2_fwd);
                    speed_drive(smcd_pkg::SPEED_MID, m1_duty, m1_fwd);
                    status = smcd_pkg::ST_OVERCURRENT;
                end
                channel = ~channel;
            end
            next.status         = status;
            next.motor1_duty    = m1_duty;
            next.motor1_forward = m1_fwd;
            next.motor2_duty    = m2_duty;
            next.motor2_forward = m2_fwd;
            next.sample_channel = channel;
            drive_q.push_back(next);
        endfunction

        function void compare_field(input string name, input logic [9:0] want,
                                    input logic [9:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input smcd_pkg::t_cmd_out got);
            smcd_pkg::t_cmd_out want;
            if (drive_q.size() == 0) begin
                $display("%0t: result with no item outstanding, expected none, actual %p",
                         $time, got);
                errors++;
                return;
            end
            want = drive_q.pop_front();
            compare_field("status", 10'(want.status), 10'(got.status));
            compare_field("motor1_duty", want.motor1_duty, got.motor1_duty);
            compare_field("motor1_forward", 10'(want.motor1_forward), 10'(got.motor1_forward));
            compare_field("motor2_duty", want.motor2_duty, got.motor2_duty);
            compare_field("motor2_forward", 10'(want.motor2_forward), 10'(got.motor2_forward));
            compare_field("sample_channel", 10'(want.sample_channel), 10'(got.sample_channel));
        endfunction
    endclass

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_stall;
    smcd_pkg::t_cmd_in  i_in_item     = '0;
    logic               o_out_valid;
    logic               i_out_stall   = 1'b0;
    smcd_pkg::t_cmd_out o_out_item;
    logic               i_cfg_wr_en   = 1'b0;
    logic [9:0]         i_cfg_wr_data = '0;

    drive_tracker board = new();
    int items_sent  = 0;
    int cycle_count = 0;
    int stall_left  = 0;
    bit quiet       = 1'b0;

    serial_motor_command_driver_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_item     (i_in_item),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                board.check_result(o_out_item);
                stall_left = quiet ? 0 : int'($urandom_range(0, MAX_IDLE));
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input smcd_pkg::t_cmd_in it);
        int gap;
        gap = quiet ? 0 : int'($urandom_range(0, MAX_IDLE));
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        board.note_item(it);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] value);
        smcd_pkg::t_cmd_in it;
        it.action       = smcd_pkg::ACT_BYTE;
        it.byte_value   = value;
        it.sample_value = 10'($urandom);
        send_item(it);
    endtask

    task automatic send_sample(input logic [9:0] value);
        smcd_pkg::t_cmd_in it;
        it.action       = smcd_pkg::ACT_SAMPLE;
        it.byte_value   = 8'($urandom);
        it.sample_value = value;
        send_item(it);
    endtask

    task automatic send_command(input logic [7:0] motor, input logic [7:0] speed);
        send_byte(motor);
        send_byte(speed);
        send_byte(smcd_pkg::CHAR_CR);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.drive_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [9:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        board.threshold = value;
    endtask

    function automatic logic [7:0] non_cr_byte();
        logic [7:0] b;
        b = 8'($urandom);
        return (b == smcd_pkg::CHAR_CR) ? (b ^ 8'h01) : b;
    endfunction

    function automatic logic [9:0] random_sample();
        int level;
        if ($urandom_range(0, 1) == 0) begin
            return 10'($urandom);
        end
        level = int'(board.threshold) + int'($urandom_range(0, 2)) - 1;
        if (level < 0) begin
            level = 0;
        end else if (level > int'(smcd_pkg::DUTY_MAX)) begin
            level = int'(smcd_pkg::DUTY_MAX);
        end
        return level[9:0];
    endfunction

    task automatic random_burst();
        int kind;
        int len;
        logic [7:0] motor;
        kind = int'($urandom_range(0, 99));
        if ($urandom_range(0, 9) == 0) begin
            quiet = ~quiet;
        end
        if (kind < 2) begin
            drain();
        end
        if (kind < 55) begin
            motor = ($urandom_range(0, 1) == 0) ? smcd_pkg::CHAR_M1 : smcd_pkg::CHAR_M2;
            send_byte(motor);
            if ($urandom_range(0, 5) == 0) begin
                send_sample(random_sample());
            end
            send_byte(8'($urandom));
            send_byte(smcd_pkg::CHAR_CR);
        end else if (kind < 70) begin
            send_sample(random_sample());
        end else if (kind < 78) begin
            send_command(non_cr_byte(), 8'($urandom));
        end else if (kind < 88) begin
            len = int'($urandom_range(0, smcd_pkg::CMD_MAX_LEN + 3));
            repeat (len) send_byte(non_cr_byte());
            send_byte(smcd_pkg::CHAR_CR);
        end else if (kind < 94) begin
            send_byte(8'($urandom));
        end else begin
            send_sample(10'($urandom));
        end
    endtask

    initial begin
        logic [9:0] level;
        int phase_end;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_command(smcd_pkg::CHAR_M1, 8'hFF);
        send_command(smcd_pkg::CHAR_M2, 8'h00);
        send_command(smcd_pkg::CHAR_M2, smcd_pkg::SPEED_MID - 8'd1);
        send_byte(smcd_pkg::CHAR_CR);
        send_command(8'h30, 8'h00);
        for (int k = 0; k < smcd_pkg::CMD_MAX_LEN; k++) begin
            send_byte(k[0] ? 8'hFF : 8'h00);
        end
        drain();
        write_threshold(10'd0);
        send_sample(10'd0);
        send_sample(10'd1);
        send_sample(smcd_pkg::DUTY_MAX);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    level = smcd_pkg::THRESHOLD_INIT;
                end
                1: begin
                    level = 10'd0;
                end
                2: begin
                    level = 10'd1;
                end
                default: begin
                    level = 10'($urandom);
                end
            endcase
            drain();
            write_threshold(level);
            phase_end = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < phase_end) random_burst();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.drive_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/smcd_pkg.sv
rtl/smcd_engine.sv
rtl/serial_motor_command_driver_core.sv
dv/tb_top.sv
